FILE: src/nkc_pkg.sv
// ----------------------------------------------------------------------------
// nkc_pkg: shared types and constants
// Widths, register indexes, command codes and the divider cell record used by
// the normalized kernel convolution block.
// ----------------------------------------------------------------------------
package nkc_pkg;

  // Pixel channel and configuration port widths.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned RGB_W      = 3 * PIX_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned HEIGHT_CAP = 2048;

  // Arithmetic widths, sized for 25 taps of 8-bit weights.
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned DVS_W   = 12;
  localparam int unsigned WSUM_W  = DVS_W + 1;
  localparam int unsigned Q_W     = 8;
  localparam int unsigned LANES   = 3;
  localparam int unsigned KCOLS   = 5;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd3;

  // Input commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Record that travels down the divider chain; per-lane fields, shared divisor.
  typedef struct packed {
    logic [LANES-1:0][SUM_W-1:0] rem;
    logic [LANES-1:0][Q_W-1:0]   quo;
    logic [LANES-1:0]            sat;
    logic [LANES-1:0]            neg;
    logic [DVS_W-1:0]            dvs;
  } div_data_t;

endpackage

FILE: src/nkc_if.sv
// ----------------------------------------------------------------------------
// nkc_if: channel interfaces
// Pixel request, result request and configuration write channels.
// ----------------------------------------------------------------------------
interface nkc_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [nkc_pkg::PIX_W-1:0] in_red;
  logic [nkc_pkg::PIX_W-1:0] in_green;
  logic [nkc_pkg::PIX_W-1:0] in_blue;

  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface nkc_res_if;
  logic                      valid;
  logic                      ready;
  logic [nkc_pkg::PIX_W-1:0] out_red;
  logic [nkc_pkg::PIX_W-1:0] out_green;
  logic [nkc_pkg::PIX_W-1:0] out_blue;
  logic                      frame_end;
  logic                      zero_weight_sum;

  modport source (output valid, out_red, out_green, out_blue, frame_end,
                  zero_weight_sum, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end,
                zero_weight_sum, output ready);
endinterface

interface nkc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nkc_pkg::CFG_IDX_W-1:0]  index;
  logic [nkc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/nkc_div_cell.sv
// ----------------------------------------------------------------------------
// nkc_div_cell: one stage of the divider chain
// Resolves one quotient bit per lane (or the saturation test in the top
// cell) and hands the record to the next cell every cycle.
// ----------------------------------------------------------------------------
module nkc_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  nkc_pkg::div_data_t data_i,
  output logic               valid_o,
  output nkc_pkg::div_data_t data_o
);
  import nkc_pkg::*;

  logic [SUM_W-1:0] step;
  div_data_t        data_d;
  div_data_t        data_q;
  logic             valid_q;

  assign step = SUM_W'(data_i.dvs) << SHIFT;

  generate
    if (SHIFT >= Q_W) begin : g_sat
      // Quotient would need more than Q_W bits: mark the lane saturated.
      always_comb begin
        data_d = data_i;
        for (int l = 0; l < LANES; l++) begin
          if (data_i.rem[l] >= step) begin
            data_d.sat[l] = 1'b1;
          end
        end
      end
    end else begin : g_bit
      // Restoring step: subtract the shifted divisor when it fits.
      always_comb begin
        data_d = data_i;
        for (int l = 0; l < LANES; l++) begin
          if (!data_i.sat[l] && data_i.rem[l] >= step) begin
            data_d.rem[l]        = data_i.rem[l] - step;
            data_d.quo[l][SHIFT] = 1'b1;
          end
        end
      end
    end
  endgenerate

  // Valid bit is reset; the record itself is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/normalized_kernel_convolution.sv
// ----------------------------------------------------------------------------
// normalized_kernel_convolution: RGB convolution with a normalized kernel
// Streams a frame through a pixel ring store and filters each pixel once
// its full window has arrived; border pixels pass through unfiltered.
// ----------------------------------------------------------------------------
// A pixel or drain request that produces no result leaves the block idle. A
// request that releases a result holds off the next request while its
// window is read and normalized and until the sink takes the result. This
// hold-off is set by the single read port of the pixel ring store, which is
// read once per window tap, and by the nine-cell divider chain that normalizes
// the weighted sums. The ring store holds 2*MAX_RADIUS*MAX_WIDTH +
// 2*MAX_RADIUS + 1 pixels and needs no clearing after reset. Configuration
// is taken only while the block is idle, and a pending configuration write
// holds off pixel requests for that cycle; geometry writes restart the frame.
module normalized_kernel_convolution #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_RADIUS = 2,
  parameter int unsigned COEF_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nkc_pix_if.sink   in_i,
  nkc_res_if.source out_o,
  nkc_cfg_if.sink   cfg_i
);
  import nkc_pkg::*;

  localparam int unsigned DEPTH  = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned EXT_W  = ADDR_W + 1;
  localparam int unsigned POS_W  = 2 * DIM_W;
  localparam int unsigned CELLS  = Q_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CENTER, ST_WALK, ST_FINISH, ST_LAUNCH, ST_WAIT, ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [1:0]            radius_q;
  logic [DIM_W-1:0]      width_q;
  logic [DIM_W-1:0]      height_q;
  logic [CFG_DATA_W-1:0] coef_q [KCOLS];

  // Frame counters.
  logic [POS_W-1:0]  in_pos_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [ADDR_W-1:0] in_addr_q;
  logic [ADDR_W-1:0] o_addr_q;
  logic [DIM_W-1:0]  x_q;
  logic [DIM_W-1:0]  y_q;

  // Window walk.
  logic [ADDR_W-1:0] row_addr_q;
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        ix_q;
  logic [2:0]        iy_q;
  logic              tag_mac_q;
  logic              tag_ctr_q;
  logic [2:0]        tag_ix_q;
  logic [2:0]        tag_iy_q;
  logic [RGB_W-1:0]  rdata_q;
  logic [RGB_W-1:0]  pix_q;
  logic signed [SUM_W-1:0]  acc_q [LANES];
  logic signed [WSUM_W-1:0] wsum_q;
  logic              pass_q;

  // Ring store.
  logic [RGB_W-1:0]  mem_q [DEPTH];
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] rd_addr;
  logic [RGB_W-1:0]  in_pix;

  // Result registers.
  logic             out_valid_q;
  logic [PIX_W-1:0] res_q [LANES];
  logic             frame_end_q;
  logic             zero_sum_q;

  // Effective geometry.
  logic [1:0]        eff_r;
  logic [DIM_W-1:0]  eff_w;
  logic [DIM_W-1:0]  eff_h;
  logic [2:0]        two_r;
  logic [POS_W-1:0]  total;
  logic [EXT_W-1:0]  lag;
  logic [EXT_W-1:0]  base;
  logic              in_accept;
  logic              cfg_accept;
  logic              geo_write;
  logic              in_full;
  logic              emit_pix;
  logic              emit_drain;
  logic              interior;
  logic              last_out;

  always_comb begin
    if (radius_q == 2'd0) begin
      eff_r = 2'd1;
    end else if (32'(radius_q) > MAX_RADIUS) begin
      eff_r = 2'(MAX_RADIUS);
    end else begin
      eff_r = radius_q;
    end
    if (width_q == '0) begin
      eff_w = DIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = DIM_W'(1);
    end else if (32'(height_q) > HEIGHT_CAP) begin
      eff_h = DIM_W'(HEIGHT_CAP);
    end else begin
      eff_h = height_q;
    end
  end

  assign two_r = {eff_r, 1'b0};
  assign total = POS_W'(eff_w) * POS_W'(eff_h);
  assign lag   = (eff_r == 2'd2) ? (EXT_W'(eff_w) << 1) + EXT_W'(2)
                                 : EXT_W'(eff_w) + EXT_W'(1);

  // Start of the window in the ring, wrapped below zero.
  assign base = (EXT_W'(o_addr_q) >= lag) ? EXT_W'(o_addr_q) - lag
                                          : EXT_W'(o_addr_q) + EXT_W'(DEPTH) - lag;

  assign in_accept  = in_i.valid && in_i.ready;
  assign cfg_accept = cfg_i.valid && cfg_i.ready;
  assign geo_write  = cfg_accept && (cfg_i.index == REG_RADIUS ||
                      cfg_i.index == REG_WIDTH || cfg_i.index == REG_HEIGHT);
  assign in_full    = in_pos_q >= total;
  assign emit_pix   = (in_pos_q + POS_W'(1) - out_pos_q) > POS_W'(lag);
  assign emit_drain = in_full && (out_pos_q < total);
  assign last_out   = (out_pos_q + POS_W'(1)) >= total;
  assign interior   = (x_q >= DIM_W'(eff_r)) && (x_q + DIM_W'(eff_r) < eff_w) &&
                      (y_q >= DIM_W'(eff_r)) && (y_q + DIM_W'(eff_r) < eff_h);

  // Configuration is taken only when idle, and it takes precedence there.
  assign in_i.ready  = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_i.ready = (state_q == ST_IDLE);

  assign in_pix  = {in_i.in_red, in_i.in_green, in_i.in_blue};
  assign mem_we  = in_accept && (in_i.cmd == CMD_PIXEL) && !in_full;
  assign mem_re  = (state_q == ST_CENTER) || (state_q == ST_WALK);
  assign rd_addr = (state_q == ST_CENTER) ? o_addr_q : addr_q;

  // Ring store: one write on pixel arrival, one registered read per tap.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[in_addr_q] <= in_pix;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Weight of the tap whose pixel is in the read register.
  logic [PIX_W-1:0]           wbyte;
  logic signed [COEF_BITS-1:0] wfield;
  logic signed [WSUM_W-1:0]   wext;

  assign wbyte  = coef_q[tag_ix_q][{tag_iy_q, 3'b000} +: PIX_W];
  assign wfield = wbyte[COEF_BITS-1:0];
  assign wext   = WSUM_W'(wfield);

  // Per-tap weighted products of the three channels.
  logic signed [SUM_W-1:0] prod [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod[l] = $signed({1'b0, rdata_q[(LANES-1-l)*PIX_W +: PIX_W]}) * wfield;
    end
  end

  // Divider chain input.
  div_data_t div_in;

  always_comb begin
    div_in     = '0;
    div_in.dvs = wsum_q[WSUM_W-1] ? DVS_W'(-wsum_q) : DVS_W'(wsum_q);
    for (int l = 0; l < LANES; l++) begin
      div_in.neg[l] = acc_q[l][SUM_W-1] ^ wsum_q[WSUM_W-1];
      div_in.rem[l] = acc_q[l][SUM_W-1] ? SUM_W'(-acc_q[l]) : SUM_W'(acc_q[l]);
    end
  end

  logic      chain_valid [CELLS+1];
  div_data_t chain_data [CELLS+1];

  assign chain_valid[0] = (state_q == ST_LAUNCH);
  assign chain_data[0]  = div_in;

  generate
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
      nkc_div_cell #(
        .SHIFT(Q_W - g)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .valid_i(chain_valid[g]),
        .data_i (chain_data[g]),
        .valid_o(chain_valid[g+1]),
        .data_o (chain_data[g+1])
      );
    end
  endgenerate

  // Final channel values from the chain output.
  logic [PIX_W-1:0] fin [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (pass_q) begin
        fin[l] = pix_q[(LANES-1-l)*PIX_W +: PIX_W];
      end else if (chain_data[CELLS].neg[l]) begin
        fin[l] = '0;
      end else if (chain_data[CELLS].sat[l]) begin
        fin[l] = '1;
      end else begin
        fin[l] = chain_data[CELLS].quo[l];
      end
    end
  end

  // Wrapped ring address steps.
  logic [EXT_W-1:0] addr_inc;
  logic [EXT_W-1:0] row_inc;
  logic [ADDR_W-1:0] addr_next;
  logic [ADDR_W-1:0] row_next;

  assign addr_inc  = EXT_W'(addr_q) + EXT_W'(1);
  assign row_inc   = EXT_W'(row_addr_q) + EXT_W'(eff_w);
  assign addr_next = (addr_inc >= EXT_W'(DEPTH)) ? ADDR_W'(addr_inc - EXT_W'(DEPTH))
                                                : ADDR_W'(addr_inc);
  assign row_next  = (row_inc >= EXT_W'(DEPTH)) ? ADDR_W'(row_inc - EXT_W'(DEPTH))
                                               : ADDR_W'(row_inc);

  // Sequencer, counters and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= 2'd1;
      width_q     <= DIM_W'(640);
      height_q    <= DIM_W'(480);
      for (int i = 0; i < KCOLS; i++) begin
        coef_q[i] <= '0;
      end
      in_pos_q    <= '0;
      out_pos_q   <= '0;
      in_addr_q   <= '0;
      o_addr_q    <= '0;
      x_q         <= '0;
      y_q         <= '0;
      tag_mac_q   <= 1'b0;
      tag_ctr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tag_mac_q <= (state_q == ST_WALK);
      tag_ctr_q <= (state_q == ST_CENTER);
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_i.cmd == CMD_PIXEL) begin
              if (!in_full) begin
                in_pos_q  <= in_pos_q + POS_W'(1);
                in_addr_q <= (32'(in_addr_q) == DEPTH - 1) ? '0 : in_addr_q + ADDR_W'(1);
                if (emit_pix) begin
                  state_q <= ST_CENTER;
                end
              end
            end else if (emit_drain) begin
              state_q <= ST_CENTER;
            end
          end
        end
        ST_CENTER: begin
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (ix_q == two_r && iy_q == two_r) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_q <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (chain_valid[CELLS]) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
            if (last_out) begin
              in_pos_q  <= '0;
              out_pos_q <= '0;
              in_addr_q <= '0;
              o_addr_q  <= '0;
              x_q       <= '0;
              y_q       <= '0;
            end else begin
              out_pos_q <= out_pos_q + POS_W'(1);
              o_addr_q  <= (32'(o_addr_q) == DEPTH - 1) ? '0 : o_addr_q + ADDR_W'(1);
              if (x_q + DIM_W'(1) == eff_w) begin
                x_q <= '0;
                y_q <= y_q + DIM_W'(1);
              end else begin
                x_q <= x_q + DIM_W'(1);
              end
            end
          end
        end
        ST_OUT: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Configuration writes; geometry changes restart the frame.
      if (cfg_accept) begin
        case (cfg_i.index)
          REG_RADIUS: radius_q <= cfg_i.data[1:0];
          REG_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
          REG_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
          default: begin
            coef_q[3'(cfg_i.index - REG_COEF0)] <= cfg_i.data;
          end
        endcase
      end
      if (geo_write) begin
        in_pos_q  <= '0;
        out_pos_q <= '0;
        in_addr_q <= '0;
        o_addr_q  <= '0;
        x_q       <= '0;
        y_q       <= '0;
      end
    end
  end

  // Window walk datapath: addresses, taps and accumulators.
  always_ff @(posedge clk_i) begin
    tag_ix_q <= ix_q;
    tag_iy_q <= iy_q;
    if (tag_ctr_q) begin
      pix_q <= rdata_q;
    end
    if (state_q == ST_CENTER) begin
      addr_q     <= ADDR_W'(base);
      row_addr_q <= ADDR_W'(base);
      ix_q       <= '0;
      iy_q       <= '0;
      wsum_q     <= '0;
      for (int l = 0; l < LANES; l++) begin
        acc_q[l] <= '0;
      end
    end else begin
      if (state_q == ST_WALK) begin
        if (ix_q == two_r) begin
          ix_q       <= '0;
          iy_q       <= iy_q + 3'd1;
          addr_q     <= row_next;
          row_addr_q <= row_next;
        end else begin
          ix_q   <= ix_q + 3'd1;
          addr_q <= addr_next;
        end
      end
      if (tag_mac_q) begin
        wsum_q <= wsum_q + wext;
        for (int l = 0; l < LANES; l++) begin
          acc_q[l] <= acc_q[l] + prod[l];
        end
      end
    end
    if (state_q == ST_LAUNCH) begin
      pass_q <= (wsum_q == '0) || !interior;
    end
    if (state_q == ST_WAIT && chain_valid[CELLS]) begin
      for (int l = 0; l < LANES; l++) begin
        res_q[l] <= fin[l];
      end
      frame_end_q <= last_out;
      zero_sum_q  <= (wsum_q == '0);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_red         = res_q[0];
  assign out_o.out_green       = res_q[1];
  assign out_o.out_blue        = res_q[2];
  assign out_o.frame_end       = frame_end_q;
  assign out_o.zero_weight_sum = zero_sum_q;

endmodule

FILE: src/nkc_checker.sv
// ----------------------------------------------------------------------------
// nkc_checker: port-level checks
// Watches the request channels of the convolution block over time.
// ----------------------------------------------------------------------------
module nkc_port_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // A pending result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped before it was taken");

  // No new request is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while a result is pending");

  // A result never shows in the cycle after a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i)
    else $error("result appeared too early");

  // Results leave one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("second result without a new request");

endmodule

bind normalized_kernel_convolution nkc_port_props u_nkc_port_props (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready)
);
